[design/cam_pkg.sv]
// Shared types, constants and event codes for the channel alarm monitor.
`timescale 1ns / 1ps

package cam_pkg;

  // Number of monitored channels and the index width that addresses them.
  localparam int unsigned CHANNELS = 8;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Alarm flag bit positions within one channel's flag word.
  localparam int unsigned FLAG_W     = 6;
  localparam int unsigned FLAG_LOCK  = 0;
  localparam int unsigned FLAG_PLOW  = 1;
  localparam int unsigned FLAG_PHIGH = 2;
  localparam int unsigned FLAG_BER   = 3;
  localparam int unsigned FLAG_OFS   = 4;
  localparam int unsigned FLAG_SNR   = 5;

  typedef enum logic [1:0] {
    LOCK_NONE   = 2'd0,
    LOCK_LOST   = 2'd1,
    LOCK_GAINED = 2'd2
  } lock_ev_t;

  typedef enum logic [1:0] {
    PWR_NONE   = 2'd0,
    PWR_LOW    = 2'd1,
    PWR_HIGH   = 2'd2,
    PWR_NORMAL = 2'd3
  } pwr_ev_t;

  typedef enum logic [1:0] {
    SNR_NONE      = 2'd0,
    SNR_LOW       = 2'd1,
    SNR_RECOVERED = 2'd2
  } snr_ev_t;

  typedef enum logic [1:0] {
    OFS_NONE      = 2'd0,
    OFS_LARGE     = 2'd1,
    OFS_RECOVERED = 2'd2
  } ofs_ev_t;

  typedef enum logic [1:0] {
    BER_NONE      = 2'd0,
    BER_LARGE     = 2'd1,
    BER_RECOVERED = 2'd2
  } ber_ev_t;

  // One measurement report as held in the input register.
  typedef struct packed {
    logic [2:0]         channel;
    logic               fec_locked;
    logic signed [15:0] power_level;
    logic [15:0]        snr_value;
    logic signed [31:0] freq_offset;
    logic [23:0]        ber_value;
    logic signed [15:0] power_low_limit;
    logic signed [15:0] power_high_limit;
    logic [15:0]        snr_low_limit;
    logic signed [31:0] offset_max;
    logic [23:0]        ber_max;
  } report_t;

  // One result word.
  typedef struct packed {
    logic [2:0] event_channel;
    lock_ev_t   lock_event;
    pwr_ev_t    power_event;
    snr_ev_t    snr_event;
    ofs_ev_t    offset_event;
    ber_ev_t    ber_event;
  } result_t;

  // Flag store write request.
  typedef struct packed {
    logic                en;
    logic [CH_IDX_W-1:0] idx;
    logic [FLAG_W-1:0]   flags;
  } flag_wr_t;

endpackage

[design/cam_if.sv]
// Valid/ready channel interfaces for reports and event words.
`timescale 1ns / 1ps

interface cam_rpt_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel;
  logic               fec_locked;
  logic signed [15:0] power_level;
  logic [15:0]        snr_value;
  logic signed [31:0] freq_offset;
  logic [23:0]        ber_value;
  logic signed [15:0] power_low_limit;
  logic signed [15:0] power_high_limit;
  logic [15:0]        snr_low_limit;
  logic signed [31:0] offset_max;
  logic [23:0]        ber_max;

  modport source (
    output valid, channel, fec_locked, power_level, snr_value, freq_offset, ber_value,
           power_low_limit, power_high_limit, snr_low_limit, offset_max, ber_max,
    input  ready
  );
  modport sink (
    input  valid, channel, fec_locked, power_level, snr_value, freq_offset, ber_value,
           power_low_limit, power_high_limit, snr_low_limit, offset_max, ber_max,
    output ready
  );
endinterface

interface cam_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_channel;
  logic [1:0] lock_event;
  logic [1:0] power_event;
  logic [1:0] snr_event;
  logic [1:0] offset_event;
  logic [1:0] ber_event;

  modport source (
    output valid, event_channel, lock_event, power_event, snr_event, offset_event,
           ber_event,
    input  ready
  );
  modport sink (
    input  valid, event_channel, lock_event, power_event, snr_event, offset_event,
           ber_event,
    output ready
  );
endinterface

[design/cam_flags.sv]
// Per-channel alarm flag store, cleared by reset, one read and one write port.
`timescale 1ns / 1ps

module cam_flags (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [cam_pkg::CH_IDX_W-1:0]        rd_idx,
  output logic [cam_pkg::FLAG_W-1:0]          rd_flags,
  input  cam_pkg::flag_wr_t                   wr
);

  logic [cam_pkg::FLAG_W-1:0] flags [cam_pkg::CHANNELS];

  // Combinational read of the channel in the input register.
  assign rd_flags = flags[rd_idx];

  // Write back the updated flags of the channel that just finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(cam_pkg::CHANNELS); i++) begin
        flags[i] <= '0;
      end
    end else if (wr.en) begin
      flags[wr.idx] <= wr.flags;
    end
  end

endmodule

[design/cam_eval.sv]
// Alarm evaluation: turns one report and its channel's flags into events and new flags.
`timescale 1ns / 1ps

module cam_eval (
  input  cam_pkg::report_t                 rpt,
  input  logic [cam_pkg::FLAG_W-1:0]       cur_flags,
  output logic [cam_pkg::CH_IDX_W-1:0]     idx,
  output logic                             in_range,
  output logic [cam_pkg::FLAG_W-1:0]       new_flags,
  output cam_pkg::result_t                 res
);

  assign idx      = cam_pkg::CH_IDX_W'(rpt.channel);
  assign in_range = 32'(rpt.channel) < cam_pkg::CHANNELS;

  // Lock check first; the other checks only run on a locked channel.
  always_comb begin
    logic [cam_pkg::FLAG_W-1:0] f;
    logic signed [15:0] pwr;
    logic signed [15:0] plo;
    logic signed [15:0] phi;
    logic signed [31:0] ofs;
    logic signed [31:0] omax;
    f    = cur_flags;
    pwr  = rpt.power_level;
    plo  = rpt.power_low_limit;
    phi  = rpt.power_high_limit;
    ofs  = rpt.freq_offset;
    omax = rpt.offset_max;

    res.event_channel = rpt.channel;
    res.lock_event    = cam_pkg::LOCK_NONE;
    res.power_event   = cam_pkg::PWR_NONE;
    res.snr_event     = cam_pkg::SNR_NONE;
    res.offset_event  = cam_pkg::OFS_NONE;
    res.ber_event     = cam_pkg::BER_NONE;

    if (in_range) begin
      if (!rpt.fec_locked && f[cam_pkg::FLAG_LOCK]) begin
        res.lock_event       = cam_pkg::LOCK_LOST;
        f[cam_pkg::FLAG_LOCK] = 1'b0;
      end else if (rpt.fec_locked && !f[cam_pkg::FLAG_LOCK]) begin
        res.lock_event       = cam_pkg::LOCK_GAINED;
        f[cam_pkg::FLAG_LOCK] = 1'b1;
      end

      if (rpt.fec_locked) begin
        // Power: low has priority over high, then the return to normal.
        if (pwr < plo && !f[cam_pkg::FLAG_PLOW]) begin
          res.power_event        = cam_pkg::PWR_LOW;
          f[cam_pkg::FLAG_PLOW]  = 1'b1;
          f[cam_pkg::FLAG_PHIGH] = 1'b0;
        end else if (pwr > phi && !f[cam_pkg::FLAG_PHIGH]) begin
          res.power_event        = cam_pkg::PWR_HIGH;
          f[cam_pkg::FLAG_PHIGH] = 1'b1;
          f[cam_pkg::FLAG_PLOW]  = 1'b0;
        end else if (pwr >= plo && pwr <= phi &&
                     (f[cam_pkg::FLAG_PLOW] || f[cam_pkg::FLAG_PHIGH])) begin
          res.power_event        = cam_pkg::PWR_NORMAL;
          f[cam_pkg::FLAG_PLOW]  = 1'b0;
          f[cam_pkg::FLAG_PHIGH] = 1'b0;
        end

        // SNR low or recovered.
        if (rpt.snr_value < rpt.snr_low_limit && !f[cam_pkg::FLAG_SNR]) begin
          res.snr_event        = cam_pkg::SNR_LOW;
          f[cam_pkg::FLAG_SNR] = 1'b1;
        end else if (rpt.snr_value >= rpt.snr_low_limit && f[cam_pkg::FLAG_SNR]) begin
          res.snr_event        = cam_pkg::SNR_RECOVERED;
          f[cam_pkg::FLAG_SNR] = 1'b0;
        end

        // Frequency offset large or recovered.
        if (ofs <= omax && f[cam_pkg::FLAG_OFS]) begin
          res.offset_event     = cam_pkg::OFS_RECOVERED;
          f[cam_pkg::FLAG_OFS] = 1'b0;
        end else if (ofs > omax && !f[cam_pkg::FLAG_OFS]) begin
          res.offset_event     = cam_pkg::OFS_LARGE;
          f[cam_pkg::FLAG_OFS] = 1'b1;
        end

        // BER large or recovered.
        if (rpt.ber_value < rpt.ber_max && f[cam_pkg::FLAG_BER]) begin
          res.ber_event        = cam_pkg::BER_RECOVERED;
          f[cam_pkg::FLAG_BER] = 1'b0;
        end else if (rpt.ber_value >= rpt.ber_max && !f[cam_pkg::FLAG_BER]) begin
          res.ber_event        = cam_pkg::BER_LARGE;
          f[cam_pkg::FLAG_BER] = 1'b1;
        end
      end
    end

    new_flags = f;
  end

endmodule

[design/channel_alarm_monitor.sv]
// Top level of the channel alarm monitor: input register, evaluation, result register.
// A report goes from the input register to the result register, shown as an event word.
// Throughput: one report per cycle while evt.ready is high; the flag read-modify-write
// of a channel completes in the cycle the report moves from input to result register.
// Reset (rst, synchronous): empties both registers and clears every channel's alarm flags.
`timescale 1ns / 1ps

module channel_alarm_monitor (
  input  logic       clk,
  input  logic       rst,
  cam_rpt_if.sink    rpt,
  cam_evt_if.source  evt
);

  logic                          s1_valid;
  cam_pkg::report_t              s1_item;
  logic                          out_valid;
  cam_pkg::result_t              out_res;
  logic                          advance;
  logic [cam_pkg::CH_IDX_W-1:0]  idx;
  logic                          in_range;
  logic [cam_pkg::FLAG_W-1:0]    cur_flags;
  logic [cam_pkg::FLAG_W-1:0]    new_flags;
  cam_pkg::result_t              res_next;
  cam_pkg::flag_wr_t             flag_wr;

  // The input register moves on whenever the result register is free or being emptied.
  assign advance   = !out_valid || evt.ready;
  assign rpt.ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rpt.ready) begin
      s1_valid <= rpt.valid;
    end
    if (rpt.valid && rpt.ready) begin
      s1_item.channel          <= rpt.channel;
      s1_item.fec_locked       <= rpt.fec_locked;
      s1_item.power_level      <= rpt.power_level;
      s1_item.snr_value        <= rpt.snr_value;
      s1_item.freq_offset      <= rpt.freq_offset;
      s1_item.ber_value        <= rpt.ber_value;
      s1_item.power_low_limit  <= rpt.power_low_limit;
      s1_item.power_high_limit <= rpt.power_high_limit;
      s1_item.snr_low_limit    <= rpt.snr_low_limit;
      s1_item.offset_max       <= rpt.offset_max;
      s1_item.ber_max          <= rpt.ber_max;
    end
  end

  cam_flags u_flags (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (idx),
    .rd_flags (cur_flags),
    .wr       (flag_wr)
  );

  cam_eval u_eval (
    .rpt       (s1_item),
    .cur_flags (cur_flags),
    .idx       (idx),
    .in_range  (in_range),
    .new_flags (new_flags),
    .res       (res_next)
  );

  // Flags are written back as the word leaves the input register.
  assign flag_wr.en    = advance && s1_valid && in_range;
  assign flag_wr.idx   = idx;
  assign flag_wr.flags = new_flags;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      out_res <= res_next;
    end
  end

  assign evt.valid         = out_valid;
  assign evt.event_channel = out_res.event_channel;
  assign evt.lock_event    = out_res.lock_event;
  assign evt.power_event   = out_res.power_event;
  assign evt.snr_event     = out_res.snr_event;
  assign evt.offset_event  = out_res.offset_event;
  assign evt.ber_event     = out_res.ber_event;

  // A lost lock stops every other check of that report.
  a_lost_lock_quiet: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.lock_event == cam_pkg::LOCK_LOST) |->
      (evt.power_event == cam_pkg::PWR_NONE && evt.snr_event == cam_pkg::SNR_NONE &&
       evt.offset_event == cam_pkg::OFS_NONE && evt.ber_event == cam_pkg::BER_NONE))
    else $error("lost lock word carries other events");

  // Power low and power high are never written back together.
  a_power_flags: assert property (@(posedge clk) disable iff (rst)
    flag_wr.en |-> !(flag_wr.flags[cam_pkg::FLAG_PLOW] && flag_wr.flags[cam_pkg::FLAG_PHIGH]))
    else $error("power low and high flags both set");

  // A word enters the result register only from a full input register.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(s1_valid))
    else $error("event word appeared without a report");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("registers not empty after reset");

endmodule
